### rtl/three_key_input_repeat_controller_unit_assert.svh
// Assertion helpers for the key controller, sampled on clk, disabled in reset.
`ifndef THREE_KEY_INPUT_REPEAT_CONTROLLER_UNIT_ASSERT_SVH
`define THREE_KEY_INPUT_REPEAT_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TKIRC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkirc assertion failed");

// Next-cycle implication.
`define TKIRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkirc assertion failed");

`endif

### rtl/tkirc_pkg.sv
package tkirc_pkg;

    localparam int CFG_WIDTH           = 16;
    localparam int CFG_INDEX_WIDTH     = 8;
    localparam int DIFF_WIDTH          = 16;
    localparam int DEFAULT_COUNT_WIDTH = 16;
    localparam int DEFAULT_TIMER_WIDTH = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE     = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REPEAT_START = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REPEAT_MIN   = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_PRESS   = 8'd3;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET     = 16'd50;
    localparam logic [CFG_WIDTH-1:0] REPEAT_START_RESET = 16'd300;
    localparam logic [CFG_WIDTH-1:0] REPEAT_MIN_RESET   = 16'd20;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET   = 16'd5000;

    localparam int KEY_LEFT  = 0;
    localparam int KEY_RIGHT = 1;
    localparam int KEY_OK    = 2;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_REPEAT,
        MODE_LONG
    } mode_t;

    typedef enum logic [1:0] {
        DIR_STOP,
        DIR_UP,
        DIR_DOWN
    } dir_t;

endpackage

### rtl/tkirc_shrink.sv
module tkirc_shrink #(
    parameter int TIMER_WIDTH = tkirc_pkg::DEFAULT_TIMER_WIDTH
) (
    input  logic [TIMER_WIDTH-1:0] period,
    output logic [TIMER_WIDTH-1:0] shrunk
);

    localparam int SHIFT = TIMER_WIDTH + 3;
    localparam logic [TIMER_WIDTH-1:0] RECIP =
        TIMER_WIDTH'(((64'd1 << SHIFT) + 64'd9) / 64'd10);

    logic [2*TIMER_WIDTH-1:0] product;
    logic [TIMER_WIDTH-1:0]   quot;
    logic [3:0]               rem;

    // floor(9p/10) = 9q + floor(9r/10), with q = p/10 and r = p%10
    assign product = (2*TIMER_WIDTH)'(period) * (2*TIMER_WIDTH)'(RECIP);
    assign quot    = TIMER_WIDTH'(product >> SHIFT);
    assign rem     = 4'(period - ((quot << 3) + (quot << 1)));
    assign shrunk  = (quot << 3) + quot
                   + ((rem == 4'd0) ? '0 : TIMER_WIDTH'(rem - 4'd1));

endmodule

### rtl/three_key_input_repeat_controller_unit.sv
// Channel        Dir  Fields (lowest bit first)
// s_axis         in   tdata: left_level, right_level, ok_level, read_req
// m_axis         out  tdata: read_valid, step_diff[15:0], key_pressed, shutdown_request
// cfg            in   cfg_we, cfg_index, cfg_data (one register per write)
//
// One tick request is taken per clock while the output is not stalled; its result
// leaves through a single output register in the next cycle. The tick update is
// combinational, built from the 9/10 interval shrink (one multiplier) and the
// lockout and timer counters. Reset restores the register defaults and clears all
// timers and the counter. A stalled output holds its result; a new request is
// taken in the cycle the held result is taken.
`include "three_key_input_repeat_controller_unit_assert.svh"

module three_key_input_repeat_controller_unit #(
    parameter int COUNT_WIDTH = tkirc_pkg::DEFAULT_COUNT_WIDTH,
    parameter int TIMER_WIDTH = tkirc_pkg::DEFAULT_TIMER_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // left, right, ok, read
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [23:0]                          m_axis_tdata,  // valid, diff, pressed, shutdown
    input  logic                                 cfg_we,
    input  logic [tkirc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tkirc_pkg::CFG_WIDTH-1:0]      cfg_data
);

    localparam int DW = tkirc_pkg::DIFF_WIDTH;
    localparam int KL = tkirc_pkg::KEY_LEFT;
    localparam int KR = tkirc_pkg::KEY_RIGHT;
    localparam int KO = tkirc_pkg::KEY_OK;

    logic [tkirc_pkg::CFG_WIDTH-1:0] debounce_reg;
    logic [tkirc_pkg::CFG_WIDTH-1:0] repeat_start_reg;
    logic [tkirc_pkg::CFG_WIDTH-1:0] repeat_min_reg;
    logic [tkirc_pkg::CFG_WIDTH-1:0] long_press_reg;

    logic [2:0]             levels_reg, levels_next;
    logic [2:0]             enables_reg, enables_next;
    logic [TIMER_WIDTH-1:0] lock_reg [3];
    logic [TIMER_WIDTH-1:0] lock_next [3];
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    tkirc_pkg::mode_t       mode_reg, mode_next;
    logic [TIMER_WIDTH-1:0] period_reg, period_next;
    tkirc_pkg::dir_t        dir_reg, dir_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   held_reg, held_next;

    logic                   out_valid_reg;
    logic [23:0]            out_data_reg, out_data_next;

    logic                   accept;
    logic [TIMER_WIDTH-1:0] shrunk;
    logic [TIMER_WIDTH-1:0] deb_load, start_load, min_load, long_load;

    function automatic logic [TIMER_WIDTH-1:0] load_ticks(
        input logic [tkirc_pkg::CFG_WIDTH-1:0] v
    );
        logic [TIMER_WIDTH-1:0] t;
        t = TIMER_WIDTH'(v);
        return (t == '0) ? TIMER_WIDTH'(1) : t;
    endfunction

    assign deb_load   = load_ticks(debounce_reg);
    assign start_load = load_ticks(repeat_start_reg);
    assign min_load   = load_ticks(repeat_min_reg);
    assign long_load  = load_ticks(long_press_reg);

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    tkirc_shrink #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_shrink (
        .period(period_reg),
        .shrunk(shrunk)
    );

    always_comb
    begin
        logic           left, right, ok, rd;
        logic           shutdown, pressed;
        logic [DW-1:0]  diff;

        left  = s_axis_tdata[0];
        right = s_axis_tdata[1];
        ok    = s_axis_tdata[2];
        rd    = s_axis_tdata[3];

        levels_next  = levels_reg;
        enables_next = enables_reg;
        lock_next    = lock_reg;
        timer_next   = timer_reg;
        mode_next    = mode_reg;
        period_next  = period_reg;
        dir_next     = dir_reg;
        count_next   = count_reg;
        held_next    = held_reg;
        shutdown     = 1'b0;
        pressed      = 1'b0;
        diff         = '0;

        // lockouts
        for (int i = 0; i < 3; i++)
        begin
            if (lock_next[i] != '0)
            begin
                lock_next[i] = lock_next[i] - TIMER_WIDTH'(1);
                if (lock_next[i] == '0)
                    enables_next[i] = 1'b1;
            end
        end

        // action timer
        if (mode_next != tkirc_pkg::MODE_IDLE)
        begin
            if (timer_next != '0)
                timer_next = timer_next - TIMER_WIDTH'(1);
            if (timer_next == '0)
            begin
                if (mode_next == tkirc_pkg::MODE_REPEAT)
                begin
                    if (dir_next == tkirc_pkg::DIR_UP)
                        count_next = count_next + COUNT_WIDTH'(1);
                    else if (dir_next == tkirc_pkg::DIR_DOWN)
                        count_next = count_next - COUNT_WIDTH'(1);
                    else
                        count_next = '0;
                    period_next = (shrunk < min_load) ? min_load : shrunk;
                    timer_next  = period_next;
                end
                else
                begin
                    shutdown  = 1'b1;
                    mode_next = tkirc_pkg::MODE_IDLE;
                end
            end
        end

        // left key
        if (enables_next[KL])
        begin
            if (left && !levels_next[KL])
            begin
                enables_next[KR] = 1'b0;
                enables_next[KO] = 1'b0;
                count_next       = count_next - COUNT_WIDTH'(1);
                dir_next         = tkirc_pkg::DIR_DOWN;
                period_next      = start_load;
                timer_next       = start_load;
                mode_next        = tkirc_pkg::MODE_REPEAT;
                levels_next[KL]  = 1'b1;
            end
            else if (!left && levels_next[KL])
            begin
                levels_next[KL]  = 1'b0;
                dir_next         = tkirc_pkg::DIR_STOP;
                mode_next        = tkirc_pkg::MODE_IDLE;
                timer_next       = '0;
                enables_next[KL] = 1'b0;
                lock_next[KL]    = deb_load;
                if (lock_next[KO] == '0)
                    enables_next[KO] = 1'b1;
                if (lock_next[KR] == '0)
                    enables_next[KR] = 1'b1;
            end
        end

        // right key
        if (enables_next[KR])
        begin
            if (right && !levels_next[KR])
            begin
                enables_next[KL] = 1'b0;
                enables_next[KO] = 1'b0;
                count_next       = count_next + COUNT_WIDTH'(1);
                dir_next         = tkirc_pkg::DIR_UP;
                period_next      = start_load;
                timer_next       = start_load;
                mode_next        = tkirc_pkg::MODE_REPEAT;
                levels_next[KR]  = 1'b1;
            end
            else if (!right && levels_next[KR])
            begin
                levels_next[KR]  = 1'b0;
                dir_next         = tkirc_pkg::DIR_STOP;
                mode_next        = tkirc_pkg::MODE_IDLE;
                timer_next       = '0;
                enables_next[KR] = 1'b0;
                lock_next[KR]    = deb_load;
                if (lock_next[KO] == '0)
                    enables_next[KO] = 1'b1;
                if (lock_next[KL] == '0)
                    enables_next[KL] = 1'b1;
            end
        end

        // ok key, active low
        if (enables_next[KO])
        begin
            if (!ok && levels_next[KO])
            begin
                enables_next[KL] = 1'b0;
                enables_next[KR] = 1'b0;
                held_next        = 1'b1;
                timer_next       = long_load;
                mode_next        = tkirc_pkg::MODE_LONG;
                levels_next[KO]  = 1'b0;
            end
            else if (ok && !levels_next[KO])
            begin
                levels_next[KO]  = 1'b1;
                held_next        = 1'b0;
                mode_next        = tkirc_pkg::MODE_IDLE;
                timer_next       = '0;
                enables_next[KO] = 1'b0;
                lock_next[KO]    = deb_load;
                if (lock_next[KR] == '0)
                    enables_next[KR] = 1'b1;
                if (lock_next[KL] == '0)
                    enables_next[KL] = 1'b1;
            end
        end

        // read and clear
        if (rd)
        begin
            if (count_next != '0)
            begin
                diff       = DW'(count_next);
                count_next = '0;
            end
            else
                pressed = held_next;
        end

        out_data_next = {5'd0, shutdown, pressed, diff, rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= tkirc_pkg::DEBOUNCE_RESET;
            repeat_start_reg <= tkirc_pkg::REPEAT_START_RESET;
            repeat_min_reg   <= tkirc_pkg::REPEAT_MIN_RESET;
            long_press_reg   <= tkirc_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tkirc_pkg::CFG_DEBOUNCE:     debounce_reg     <= cfg_data;
                tkirc_pkg::CFG_REPEAT_START: repeat_start_reg <= cfg_data;
                tkirc_pkg::CFG_REPEAT_MIN:   repeat_min_reg   <= cfg_data;
                tkirc_pkg::CFG_LONG_PRESS:   long_press_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg    <= 3'b100;
            enables_reg   <= 3'b111;
            for (int i = 0; i < 3; i++)
                lock_reg[i] <= '0;
            timer_reg     <= '0;
            mode_reg      <= tkirc_pkg::MODE_IDLE;
            period_reg    <= '0;
            dir_reg       <= tkirc_pkg::DIR_STOP;
            count_reg     <= '0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                levels_reg    <= levels_next;
                enables_reg   <= enables_next;
                lock_reg      <= lock_next;
                timer_reg     <= timer_next;
                mode_reg      <= mode_next;
                period_reg    <= period_next;
                dir_reg       <= dir_next;
                count_reg     <= count_next;
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    `TKIRC_ASSERT_IMPLY(a_timer_runs_with_mode, 1'b1,
        (mode_reg == tkirc_pkg::MODE_IDLE) == (timer_reg == '0))
    `TKIRC_ASSERT_IMPLY(a_repeat_period_nonzero,
        mode_reg == tkirc_pkg::MODE_REPEAT, period_reg != '0)
    `TKIRC_ASSERT_NEXT(a_long_press_expiry,
        accept && mode_reg == tkirc_pkg::MODE_LONG && timer_reg == TIMER_WIDTH'(1),
        m_axis_tvalid && m_axis_tdata[18])
    `TKIRC_ASSERT_NEXT(a_read_clears_count,
        accept && s_axis_tdata[3], count_reg == '0)

endmodule
